[design/cdq_pkg.sv]
// Shared types and constants for the circular deque core.
package cdq_pkg;

  // Request codes carried on in_tuser
  typedef enum logic [2:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_PEEK_FRONT = 3'd4
  } cdq_req_t;

  // Result status codes carried on out_tuser
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } cdq_status_t;

  localparam int unsigned REQ_W  = 3;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned OCC_W  = 4;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 40;

endpackage

[design/cdq_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module cdq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, held while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/circular_deque_core.sv]
// Circular deque core: ring storage in a RAM with head, tail and empty tracking.
// out_tvalid rises once the request has passed the response step (ST_RESP) and the output register.
// No request is taken in ST_RESP, which holds the registered ring RAM read until the output is free.
// A new request is taken while the previous result still waits on the output.
// Reset (rst_n low, synchronous) empties the queue and clears head, tail and count;
// the ring RAM is not cleared, entries are only read after they are written.
module circular_deque_core #(
  parameter int unsigned DEPTH      = 8,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Request channel
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [cdq_pkg::IN_TDATA_W-1:0]      in_tdata,   // [31:0] push_value
  input  logic [cdq_pkg::REQ_W-1:0]           in_tuser,   // [2:0] req_type
  // Result channel
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [cdq_pkg::OUT_TDATA_W-1:0]     out_tdata,  // [31:0] read_value, [35:32] occupancy
  output logic [cdq_pkg::STAT_W-1:0]          out_tuser   // [1:0] status
);

  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  typedef enum logic {
    ST_IDLE,
    ST_RESP
  } state_t;

  state_t               state_r, state_nxt;
  logic [AW-1:0]        head_r, head_nxt;
  logic [AW-1:0]        tail_r, tail_nxt;
  logic                 empty_r, empty_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic                 use_rd_r, use_rd_nxt;
  cdq_pkg::cdq_status_t pend_status_r, pend_status_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [cdq_pkg::WORD_W-1:0] out_read_r, out_read_nxt;
  cdq_pkg::cdq_status_t out_status_r, out_status_nxt;
  logic [cdq_pkg::OCC_W-1:0]  out_occ_r, out_occ_nxt;

  logic                  in_accept;
  logic                  full;
  logic                  ram_we;
  logic                  ram_re;
  logic [AW-1:0]         ram_waddr;
  logic [AW-1:0]         ram_raddr;
  logic [DATA_WIDTH-1:0] ram_wdata;
  logic [DATA_WIDTH-1:0] ram_rdata;
  logic [AW-1:0]         head_dn;
  logic [AW-1:0]         head_up;
  logic [AW-1:0]         tail_dn;
  logic [AW-1:0]         tail_up;
  logic                  load_out;

  assign in_tready = (state_r == ST_IDLE);
  assign in_accept = in_tvalid && in_tready;
  assign full      = (count_r == CNT_W'(DEPTH));
  assign ram_wdata = DATA_WIDTH'($unsigned(in_tdata[cdq_pkg::WORD_W-1:0]));

  // Wrap the ring indices
  assign head_up = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + AW'(1);
  assign head_dn = (head_r == '0) ? AW'(DEPTH - 1) : head_r - AW'(1);
  assign tail_up = (tail_r == AW'(DEPTH - 1)) ? '0 : tail_r + AW'(1);
  assign tail_dn = (tail_r == '0) ? AW'(DEPTH - 1) : tail_r - AW'(1);

  // Decode the request, update indices and issue the RAM access
  always_comb begin
    head_nxt        = head_r;
    tail_nxt        = tail_r;
    empty_nxt       = empty_r;
    count_nxt       = count_r;
    use_rd_nxt      = use_rd_r;
    pend_status_nxt = pend_status_r;
    ram_we          = 1'b0;
    ram_re          = 1'b0;
    ram_waddr       = '0;
    ram_raddr       = head_r;
    if (in_accept) begin
      use_rd_nxt      = 1'b0;
      pend_status_nxt = cdq_pkg::ST_OK;
      case (cdq_pkg::cdq_req_t'(in_tuser))
        cdq_pkg::REQ_PUSH_FRONT, cdq_pkg::REQ_PUSH_BACK: begin
          if (full) begin
            pend_status_nxt = cdq_pkg::ST_OVERFLOW;
          end else begin
            ram_we    = 1'b1;
            count_nxt = count_r + CNT_W'(1);
            if (empty_r) begin
              head_nxt  = '0;
              tail_nxt  = '0;
              empty_nxt = 1'b0;
              ram_waddr = '0;
            end else if (cdq_pkg::cdq_req_t'(in_tuser) == cdq_pkg::REQ_PUSH_FRONT) begin
              head_nxt  = head_dn;
              ram_waddr = head_dn;
            end else begin
              tail_nxt  = tail_up;
              ram_waddr = tail_up;
            end
          end
        end
        cdq_pkg::REQ_POP_FRONT, cdq_pkg::REQ_POP_BACK: begin
          if (empty_r) begin
            pend_status_nxt = cdq_pkg::ST_UNDERFLOW;
          end else begin
            ram_re     = 1'b1;
            use_rd_nxt = 1'b1;
            count_nxt  = count_r - CNT_W'(1);
            ram_raddr  = (cdq_pkg::cdq_req_t'(in_tuser) == cdq_pkg::REQ_POP_FRONT) ?
                         head_r : tail_r;
            if (head_r == tail_r) begin
              head_nxt  = '0;
              tail_nxt  = '0;
              empty_nxt = 1'b1;
            end else if (cdq_pkg::cdq_req_t'(in_tuser) == cdq_pkg::REQ_POP_FRONT) begin
              head_nxt = head_up;
            end else begin
              tail_nxt = tail_dn;
            end
          end
        end
        cdq_pkg::REQ_PEEK_FRONT: begin
          if (empty_r) begin
            pend_status_nxt = cdq_pkg::ST_UNDERFLOW;
          end else begin
            ram_re     = 1'b1;
            use_rd_nxt = 1'b1;
            ram_raddr  = head_r;
          end
        end
        default: begin
          pend_status_nxt = cdq_pkg::ST_OK;
        end
      endcase
    end
  end

  // Move the finished result into the output register when it is free
  assign load_out = (state_r == ST_RESP) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt      = state_r;
    out_valid_nxt  = out_valid_r;
    out_read_nxt   = out_read_r;
    out_status_nxt = out_status_r;
    out_occ_nxt    = out_occ_r;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = ST_RESP;
        end
        if (out_tready) begin
          out_valid_nxt = 1'b0;
        end
      end
      ST_RESP: begin
        if (load_out) begin
          state_nxt      = ST_IDLE;
          out_valid_nxt  = 1'b1;
          out_read_nxt   = use_rd_r ? cdq_pkg::WORD_W'(ram_rdata) : '0;
          out_status_nxt = pend_status_r;
          out_occ_nxt    = cdq_pkg::OCC_W'(count_r);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      empty_r     <= 1'b1;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      empty_r     <= empty_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    use_rd_r      <= use_rd_nxt;
    pend_status_r <= pend_status_nxt;
    out_read_r    <= out_read_nxt;
    out_status_r  <= out_status_nxt;
    out_occ_r     <= out_occ_nxt;
  end

  cdq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(cdq_pkg::OUT_TDATA_W - cdq_pkg::WORD_W - cdq_pkg::OCC_W){1'b0}},
                       out_occ_r, out_read_r};
  assign out_tuser  = out_status_r;

  // Occupancy never exceeds the ring size
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("deque count above depth");

  // Empty mark agrees with the entry count
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    empty_r == (count_r == '0))
    else $error("empty mark and count disagree");

  // An accepted request always moves on to the response step
  a_accept_resp: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (state_r == ST_RESP))
    else $error("accepted request did not reach response step");

  // An empty queue keeps both indices at the first slot
  a_empty_index: assert property (@(posedge clk) disable iff (!rst_n)
    empty_r |-> (head_r == '0) && (tail_r == '0))
    else $error("indices not parked while empty");

endmodule
